// ----- design/multimeter_frame_decoder_defines.svh -----
// Assertion macros shared by the RTL.
`ifndef MULTIMETER_FRAME_DECODER_DEFINES_SVH
`define MULTIMETER_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MFD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- design/mfd_pkg.sv -----
`timescale 1ns / 1ps

package mfd_pkg;

   localparam int FRAME_BYTES_DEFAULT = 16;
   // Only bytes 0..10 of a frame are ever decoded.
   localparam int DECODE_BYTES        = 11;

   localparam logic [7:0] LINE_FEED  = 8'h0A;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_QUERY = 8'h3F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_FOUR  = 8'h34;

   typedef enum logic {
      ACTION_RECEIVE = 1'b0,
      ACTION_RESYNC  = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      MODE_NONE, MODE_REL, MODE_AUTO, MODE_MAX,
      MODE_MIN, MODE_BEEP, MODE_DIODE, MODE_PERCENT
   } mode_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_AC   = 2'd1,
      KIND_DC   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      PREFIX_NONE = 3'd0,
      PREFIX_NANO = 3'd1,
      PREFIX_MICRO = 3'd2,
      PREFIX_MILLI = 3'd3,
      PREFIX_KILO = 3'd4,
      PREFIX_MEGA = 3'd5
   } prefix_type;

   typedef enum logic [3:0] {
      UNIT_NONE = 4'd0,
      UNIT_VOLT = 4'd1,
      UNIT_AMP = 4'd2,
      UNIT_OHM = 4'd3,
      UNIT_HFE = 4'd4,
      UNIT_HERTZ = 4'd5,
      UNIT_FARAD = 4'd6,
      UNIT_CELSIUS = 4'd7,
      UNIT_FAHRENHEIT = 4'd8
   } unit_type;

   typedef logic [7:0] byte_type;
   typedef byte_type frame_type [DECODE_BYTES];

   typedef struct packed {
      logic        is_positive;
      logic [31:0] digit_chars;
      logic        overload;
      logic [1:0]  point_position;
      logic        point_invalid;
      mode_type    measure_mode;
      kind_type    current_kind;
      prefix_type  metric_prefix;
      unit_type    unit_code;
   } result_type;

endpackage

// ----- design/multimeter_frame_decoder.sv -----
// A line feed sets pend_ff; the decoded frame then loads rsp_ff and rsp_valid.
// Throughput: one request per cycle; input stalls only while a decoded frame
// waits behind an output that is not taken.
// Reset: synchronous; frame bytes, index, last unit and valid flags cleared.
`timescale 1ns / 1ps
`include "multimeter_frame_decoder_defines.svh"

module multimeter_frame_decoder #(
   parameter int FRAME_BYTES = mfd_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_positive,
   output logic [31:0] rsp_digit_chars,
   output logic        rsp_overload,
   output logic [1:0]  rsp_point_position,
   output logic        rsp_point_invalid,
   output logic [2:0]  rsp_measure_mode,
   output logic [1:0]  rsp_current_kind,
   output logic [2:0]  rsp_metric_prefix,
   output logic [3:0]  rsp_unit_code
);

   localparam int IDX_W = $clog2(FRAME_BYTES + 1);

   mfd_pkg::frame_type  frame_ff, frame_in;
   logic [IDX_W-1:0]    index_ff, index_in;
   logic                pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   mfd_pkg::result_type rsp_ff, rsp_in;
   mfd_pkg::unit_type   last_unit_ff, last_unit_in;
   mfd_pkg::result_type decoded;

   logic accept, receive, line_feed, advance;

   assign advance   = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !pend_ff || advance;
   assign accept    = req_valid && req_ready;
   assign receive   = accept && (req_action == mfd_pkg::ACTION_RECEIVE);
   assign line_feed = receive && (req_rx_byte == mfd_pkg::LINE_FEED);

   mfd_decode u_decode (
      .frame     (frame_ff),
      .last_unit (last_unit_ff),
      .result    (decoded)
   );

   always_comb begin
      frame_in = frame_ff;
      for (int i = 0; i < mfd_pkg::DECODE_BYTES; i++) begin
         if (receive && index_ff == IDX_W'(i)) begin
            frame_in[i] = req_rx_byte;
         end
      end

      index_in = index_ff;
      if (accept && req_action == mfd_pkg::ACTION_RESYNC) begin
         index_in = '0;
      end else if (line_feed) begin
         index_in = '0;
      end else if (receive && index_ff < IDX_W'(FRAME_BYTES)) begin
         index_in = index_ff + 1'b1;
      end

      pend_in = line_feed ? 1'b1 : (advance ? 1'b0 : pend_ff);

      rsp_in       = advance ? decoded : rsp_ff;
      last_unit_in = advance ? decoded.unit_code : last_unit_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mfd_pkg::DECODE_BYTES; i++) begin
            frame_ff[i] <= '0;
         end
         index_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_unit_ff <= mfd_pkg::UNIT_NONE;
      end else begin
         frame_ff     <= frame_in;
         index_ff     <= index_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         last_unit_ff <= last_unit_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_positive    = rsp_ff.is_positive;
   assign rsp_digit_chars    = rsp_ff.digit_chars;
   assign rsp_overload       = rsp_ff.overload;
   assign rsp_point_position = rsp_ff.point_position;
   assign rsp_point_invalid  = rsp_ff.point_invalid;
   assign rsp_measure_mode   = rsp_ff.measure_mode;
   assign rsp_current_kind   = rsp_ff.current_kind;
   assign rsp_metric_prefix  = rsp_ff.metric_prefix;
   assign rsp_unit_code      = rsp_ff.unit_code;

   `MFD_ASSERT_NOW(a_index_bound, clock, reset, 1'b1, index_ff <= IDX_W'(FRAME_BYTES))
   `MFD_ASSERT_NEXT(a_lf_pending, clock, reset, line_feed, pend_ff && index_ff == '0)
   `MFD_ASSERT_NOW(a_stall_blocks, clock, reset, pend_ff && rsp_valid_ff && !rsp_ready, !req_ready)
   `MFD_ASSERT_NEXT(a_unit_tracks, clock, reset, advance,
                    rsp_valid_ff && rsp_ff.unit_code == last_unit_ff)

endmodule

// ----- design/mfd_decode.sv -----
`timescale 1ns / 1ps

module mfd_decode (
   input  mfd_pkg::frame_type  frame,
   input  mfd_pkg::unit_type   last_unit,
   output mfd_pkg::result_type result
);

   always_comb begin
      result.is_positive = (frame[0] == mfd_pkg::CHAR_PLUS);
      result.digit_chars = {frame[1], frame[2], frame[3], frame[4]};
      result.overload    = (frame[1] == mfd_pkg::CHAR_QUERY);

      if (frame[6] >= mfd_pkg::CHAR_ZERO && frame[6] <= mfd_pkg::CHAR_FOUR) begin
         result.point_invalid  = 1'b0;
         result.point_position = (frame[6] == mfd_pkg::CHAR_FOUR) ? 2'd3 : frame[6][1:0];
      end else begin
         result.point_invalid  = 1'b1;
         result.point_position = 2'd0;
      end

      if (frame[7][2])      result.measure_mode = mfd_pkg::MODE_REL;
      else if (frame[7][5]) result.measure_mode = mfd_pkg::MODE_AUTO;
      else if (frame[8][5]) result.measure_mode = mfd_pkg::MODE_MAX;
      else if (frame[8][4]) result.measure_mode = mfd_pkg::MODE_MIN;
      else if (frame[9][3]) result.measure_mode = mfd_pkg::MODE_BEEP;
      else if (frame[9][2]) result.measure_mode = mfd_pkg::MODE_DIODE;
      else if (frame[9][1]) result.measure_mode = mfd_pkg::MODE_PERCENT;
      else                  result.measure_mode = mfd_pkg::MODE_NONE;

      if (frame[7][3])      result.current_kind = mfd_pkg::KIND_AC;
      else if (frame[7][4]) result.current_kind = mfd_pkg::KIND_DC;
      else                  result.current_kind = mfd_pkg::KIND_NONE;

      if (frame[8][1])      result.metric_prefix = mfd_pkg::PREFIX_NANO;
      else if (frame[9][7]) result.metric_prefix = mfd_pkg::PREFIX_MICRO;
      else if (frame[9][6]) result.metric_prefix = mfd_pkg::PREFIX_MILLI;
      else if (frame[9][5]) result.metric_prefix = mfd_pkg::PREFIX_KILO;
      else if (frame[9][4]) result.metric_prefix = mfd_pkg::PREFIX_MEGA;
      else                  result.metric_prefix = mfd_pkg::PREFIX_NONE;

      case (frame[10])
         8'h80:   result.unit_code = mfd_pkg::UNIT_VOLT;
         8'h40:   result.unit_code = mfd_pkg::UNIT_AMP;
         8'h20:   result.unit_code = mfd_pkg::UNIT_OHM;
         8'h10:   result.unit_code = mfd_pkg::UNIT_HFE;
         8'h08:   result.unit_code = mfd_pkg::UNIT_HERTZ;
         8'h04:   result.unit_code = mfd_pkg::UNIT_FARAD;
         8'h02:   result.unit_code = mfd_pkg::UNIT_CELSIUS;
         8'h01:   result.unit_code = mfd_pkg::UNIT_FAHRENHEIT;
         default: result.unit_code = last_unit;
      endcase
   end

endmodule

// ----- verif/multimeter_frame_decoder_tb.sv -----
`timescale 1ns / 1ps

module multimeter_frame_decoder_tb;

   localparam int FRAME_BYTES = mfd_pkg::FRAME_BYTES_DEFAULT;
   localparam mfd_pkg::byte_type CHAR_MINUS = 8'h2D;
   localparam mfd_pkg::byte_type CHAR_SPACE = 8'h20;

   typedef struct {
      mfd_pkg::action_type act;
      mfd_pkg::byte_type   data;
      bit                  typed;
      mfd_pkg::result_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = mfd_pkg::ACTION_RECEIVE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_is_positive;
   logic [31:0] rsp_digit_chars;
   logic        rsp_overload;
   logic [1:0]  rsp_point_position;
   logic        rsp_point_invalid;
   logic [2:0]  rsp_measure_mode;
   logic [1:0]  rsp_current_kind;
   logic [2:0]  rsp_metric_prefix;
   logic [3:0]  rsp_unit_code;

   mfd_pkg::byte_type   frame_bytes [FRAME_BYTES] = '{default: 8'h00};
   int                  frame_index = 0;
   mfd_pkg::unit_type   last_unit = mfd_pkg::UNIT_NONE;
   mfd_pkg::result_type expected_readings [$];
   stim_row_type        directed_rows [$];

   bit steady = 1'b0;
   int requests_sent = 0;
   int resyncs_sent = 0;
   int readings_checked = 0;
   int overflow_frames = 0;
   int mismatches = 0;

   multimeter_frame_decoder #(
      .FRAME_BYTES(FRAME_BYTES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_is_positive(rsp_is_positive),
      .rsp_digit_chars(rsp_digit_chars),
      .rsp_overload(rsp_overload),
      .rsp_point_position(rsp_point_position),
      .rsp_point_invalid(rsp_point_invalid),
      .rsp_measure_mode(rsp_measure_mode),
      .rsp_current_kind(rsp_current_kind),
      .rsp_metric_prefix(rsp_metric_prefix),
      .rsp_unit_code(rsp_unit_code)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic bit decode_frame_byte(input mfd_pkg::action_type act,
                                            input mfd_pkg::byte_type data,
                                            output mfd_pkg::result_type reading);
      mfd_pkg::byte_type pc;
      reading = '0;
      if (act == mfd_pkg::ACTION_RESYNC) begin
         frame_index = 0;
         return 1'b0;
      end
      if (frame_index < FRAME_BYTES) begin
         frame_bytes[frame_index] = data;
         frame_index++;
      end
      if (data != mfd_pkg::LINE_FEED) return 1'b0;
      frame_index = 0;

      pc = frame_bytes[6];
      if (pc >= mfd_pkg::CHAR_ZERO && pc <= mfd_pkg::CHAR_FOUR)
         reading.point_position = (pc == mfd_pkg::CHAR_FOUR) ? 2'd3 : pc[1:0];
      else
         reading.point_invalid = 1'b1;

      case (frame_bytes[10])
         8'h80: last_unit = mfd_pkg::UNIT_VOLT;
         8'h40: last_unit = mfd_pkg::UNIT_AMP;
         8'h20: last_unit = mfd_pkg::UNIT_OHM;
         8'h10: last_unit = mfd_pkg::UNIT_HFE;
         8'h08: last_unit = mfd_pkg::UNIT_HERTZ;
         8'h04: last_unit = mfd_pkg::UNIT_FARAD;
         8'h02: last_unit = mfd_pkg::UNIT_CELSIUS;
         8'h01: last_unit = mfd_pkg::UNIT_FAHRENHEIT;
         default: ;
      endcase

      reading.is_positive = (frame_bytes[0] == mfd_pkg::CHAR_PLUS);
      reading.digit_chars = {frame_bytes[1], frame_bytes[2], frame_bytes[3], frame_bytes[4]};
      reading.overload = (frame_bytes[1] == mfd_pkg::CHAR_QUERY);

      if (frame_bytes[7][2])      reading.measure_mode = mfd_pkg::MODE_REL;
      else if (frame_bytes[7][5]) reading.measure_mode = mfd_pkg::MODE_AUTO;
      else if (frame_bytes[8][5]) reading.measure_mode = mfd_pkg::MODE_MAX;
      else if (frame_bytes[8][4]) reading.measure_mode = mfd_pkg::MODE_MIN;
      else if (frame_bytes[9][3]) reading.measure_mode = mfd_pkg::MODE_BEEP;
      else if (frame_bytes[9][2]) reading.measure_mode = mfd_pkg::MODE_DIODE;
      else if (frame_bytes[9][1]) reading.measure_mode = mfd_pkg::MODE_PERCENT;
      else                        reading.measure_mode = mfd_pkg::MODE_NONE;

      if (frame_bytes[7][3])      reading.current_kind = mfd_pkg::KIND_AC;
      else if (frame_bytes[7][4]) reading.current_kind = mfd_pkg::KIND_DC;
      else                        reading.current_kind = mfd_pkg::KIND_NONE;

      if (frame_bytes[8][1])      reading.metric_prefix = mfd_pkg::PREFIX_NANO;
      else if (frame_bytes[9][7]) reading.metric_prefix = mfd_pkg::PREFIX_MICRO;
      else if (frame_bytes[9][6]) reading.metric_prefix = mfd_pkg::PREFIX_MILLI;
      else if (frame_bytes[9][5]) reading.metric_prefix = mfd_pkg::PREFIX_KILO;
      else if (frame_bytes[9][4]) reading.metric_prefix = mfd_pkg::PREFIX_MEGA;
      else                        reading.metric_prefix = mfd_pkg::PREFIX_NONE;

      reading.unit_code = last_unit;
      return 1'b1;
   endfunction

   task automatic add_row(input mfd_pkg::action_type act, input mfd_pkg::byte_type data,
                          input bit typed, input mfd_pkg::result_type want);
      stim_row_type row;
      row.act = act;
      row.data = data;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endtask

   task automatic send_request(input mfd_pkg::action_type act, input mfd_pkg::byte_type data,
                               input bit typed, input mfd_pkg::result_type want);
      mfd_pkg::result_type reading;
      if (!steady && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (!steady && $urandom_range(99) < 26);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_rx_byte <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      if (act == mfd_pkg::ACTION_RESYNC) resyncs_sent++;
      if (decode_frame_byte(act, data, reading))
         expected_readings.push_back(typed ? want : reading);
   endtask

   task automatic send_random_burst();
      mfd_pkg::byte_type fb [mfd_pkg::DECODE_BYTES];
      mfd_pkg::byte_type data;
      int pick;
      int len;
      pick = $urandom_range(99);
      if (pick < 70) begin
         // well-formed frame, random content
         fb[0] = $urandom_range(1) ? mfd_pkg::CHAR_PLUS : CHAR_MINUS;
         if ($urandom_range(9) == 0) fb[0] = mfd_pkg::byte_type'($urandom_range(255));
         fb[1] = ($urandom_range(4) == 0) ? mfd_pkg::CHAR_QUERY
                 : mfd_pkg::byte_type'(mfd_pkg::CHAR_ZERO + $urandom_range(9));
         for (int i = 2; i < 5; i++)
            fb[i] = mfd_pkg::byte_type'(mfd_pkg::CHAR_ZERO + $urandom_range(9));
         fb[5] = $urandom_range(1) ? CHAR_SPACE : mfd_pkg::byte_type'($urandom_range(255));
         fb[6] = ($urandom_range(4) != 0)
                 ? mfd_pkg::byte_type'(mfd_pkg::CHAR_ZERO + $urandom_range(4))
                 : mfd_pkg::byte_type'($urandom_range(255));
         for (int i = 7; i < 10; i++) fb[i] = mfd_pkg::byte_type'($urandom_range(255));
         pick = $urandom_range(9);
         if (pick < 7)       fb[10] = 8'h01 << $urandom_range(7);
         else if (pick == 7) fb[10] = 8'h00;
         else                fb[10] = mfd_pkg::byte_type'($urandom_range(255));
         for (int i = 0; i < mfd_pkg::DECODE_BYTES; i++) begin
            if (fb[i] == mfd_pkg::LINE_FEED) fb[i] = 8'h0B;
            send_request(mfd_pkg::ACTION_RECEIVE, fb[i], 1'b0, '0);
         end
         send_request(mfd_pkg::ACTION_RECEIVE, mfd_pkg::LINE_FEED, 1'b0, '0);
      end else if (pick < 80) begin
         len = $urandom_range(FRAME_BYTES, FRAME_BYTES + 8);
         for (int i = 0; i < len; i++) begin
            data = mfd_pkg::byte_type'($urandom_range(255));
            if (data == mfd_pkg::LINE_FEED) data = 8'hA5;
            send_request(mfd_pkg::ACTION_RECEIVE, data, 1'b0, '0);
         end
         send_request(mfd_pkg::ACTION_RECEIVE, mfd_pkg::LINE_FEED, 1'b0, '0);
         overflow_frames++;
      end else if (pick < 90) begin
         // broken frame cut by a resync
         len = $urandom_range(0, 8);
         for (int i = 0; i < len; i++) begin
            data = mfd_pkg::byte_type'($urandom_range(255));
            if (data == mfd_pkg::LINE_FEED) data = 8'h5A;
            send_request(mfd_pkg::ACTION_RECEIVE, data, 1'b0, '0);
         end
         send_request(mfd_pkg::ACTION_RESYNC, mfd_pkg::byte_type'($urandom_range(255)),
                      1'b0, '0);
      end else begin
         len = $urandom_range(1, 6);
         for (int i = 0; i < len; i++)
            send_request(mfd_pkg::action_type'($urandom_range(3) == 0),
                         mfd_pkg::byte_type'($urandom_range(255)), 1'b0, '0);
         if ($urandom_range(1))
            send_request(mfd_pkg::ACTION_RECEIVE, mfd_pkg::LINE_FEED, 1'b0, '0);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 26);
   end

   always @(posedge clock) begin
      mfd_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) begin
            $error("reading with no request pending");
            mismatches++;
         end else begin
            want = expected_readings.pop_front();
            readings_checked++;
            check_field("is_positive", 32'(want.is_positive), 32'(rsp_is_positive));
            check_field("digit_chars", want.digit_chars, rsp_digit_chars);
            check_field("overload", 32'(want.overload), 32'(rsp_overload));
            check_field("point_position", 32'(want.point_position),
                        32'(rsp_point_position));
            check_field("point_invalid", 32'(want.point_invalid), 32'(rsp_point_invalid));
            check_field("measure_mode", 32'(want.measure_mode), 32'(rsp_measure_mode));
            check_field("current_kind", 32'(want.current_kind), 32'(rsp_current_kind));
            check_field("metric_prefix", 32'(want.metric_prefix), 32'(rsp_metric_prefix));
            check_field("unit_code", 32'(want.unit_code), 32'(rsp_unit_code));
         end
      end
   end

   initial begin
      mfd_pkg::result_type want;
      mfd_pkg::byte_type   full_frame [mfd_pkg::DECODE_BYTES];
      int random_start;

      // line feed straight out of reset: empty store, bad point char
      want = '0;
      want.point_invalid = 1'b1;
      add_row(mfd_pkg::ACTION_RECEIVE, mfd_pkg::LINE_FEED, 1'b1, want);

      // every flag at its highest priority, '4' point char
      full_frame = '{mfd_pkg::CHAR_PLUS, mfd_pkg::CHAR_QUERY, 8'h31, 8'h32, 8'h33,
                     CHAR_SPACE, mfd_pkg::CHAR_FOUR, 8'h3C, 8'h32, 8'hFE, 8'h80};
      foreach (full_frame[i]) add_row(mfd_pkg::ACTION_RECEIVE, full_frame[i], 1'b0, '0);
      want = '0;
      want.is_positive = 1'b1;
      want.digit_chars = 32'h3F313233;
      want.overload = 1'b1;
      want.point_position = 2'd3;
      want.measure_mode = mfd_pkg::MODE_REL;
      want.current_kind = mfd_pkg::KIND_AC;
      want.metric_prefix = mfd_pkg::PREFIX_NANO;
      want.unit_code = mfd_pkg::UNIT_VOLT;
      add_row(mfd_pkg::ACTION_RECEIVE, mfd_pkg::LINE_FEED, 1'b1, want);

      // short frames over stale bytes, resync mid-frame
      add_row(mfd_pkg::ACTION_RECEIVE, 8'h2D, 1'b0, '0);
      add_row(mfd_pkg::ACTION_RESYNC, 8'hFF, 1'b0, '0);
      add_row(mfd_pkg::ACTION_RECEIVE, 8'h00, 1'b0, '0);
      add_row(mfd_pkg::ACTION_RECEIVE, 8'hFF, 1'b0, '0);
      add_row(mfd_pkg::ACTION_RECEIVE, mfd_pkg::LINE_FEED, 1'b0, '0);
      add_row(mfd_pkg::ACTION_RESYNC, 8'h00, 1'b0, '0);
      add_row(mfd_pkg::ACTION_RECEIVE, mfd_pkg::LINE_FEED, 1'b0, '0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].act, directed_rows[i].data, directed_rows[i].typed,
                      directed_rows[i].want);

      random_start = requests_sent;
      while (requests_sent - random_start < 750) begin
         steady = (requests_sent - random_start >= 300) && (requests_sent - random_start < 420);
         send_random_burst();
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      while (expected_readings.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d requests (%0d resyncs), checked %0d decoded frames",
               requests_sent, resyncs_sent, readings_checked);
      $display("including %0d overflowing frames, with random stalls on both sides",
               overflow_frames);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
